// ===== hdl/utxrl_pkg.sv =====
// Shared constants for the UART transmit ring and line receiver.
// Holds the command codes, the control characters and the default depths.
// Used by the top level.
package utxrl_pkg;

   localparam int TX_DEPTH_DEF   = 1024;
   localparam int LINE_DEPTH_DEF = 256;

   localparam int CMD_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 3'd0,
      CMD_TX_RDY  = 3'd1,
      CMD_RX_BYTE = 3'd2,
      CMD_READ    = 3'd3,
      CMD_RELEASE = 3'd4
   } cmd_type;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

endpackage

// ===== hdl/utxrl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module utxrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/uart_tx_ring_and_line_receiver.sv =====
// UART transmit ring and line receive buffer, top level.
// Depends on utxrl_pkg and utxrl_ram (one instance per byte store).
//
//   channel | direction | ports                                   | accepted when
//   req     | in        | command, data_byte, read_index          | req_valid & req_ready
//   rsp     | out       | accepted, send_valid, send_byte,        | rsp_valid & rsp_ready
//           |           | send_enabled, line_ready, return_flag,  |
//           |           | line_count, read_value                  |
//
// One item per cycle unless a stalled result holds the input; each result appears
// in the cycle after its item is taken, through the stores' registered read ports.
// Reset clears the pointers, the valid bit and the state flags; the stores and the result fields are not cleared.
// A stalled result holds; a new item is taken in the cycle the result leaves.
module uart_tx_ring_and_line_receiver #(
   parameter int TX_DEPTH   = utxrl_pkg::TX_DEPTH_DEF,
   parameter int LINE_DEPTH = utxrl_pkg::LINE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accepted,
   output logic       rsp_send_valid,
   output logic [7:0] rsp_send_byte,
   output logic       rsp_send_enabled,
   output logic       rsp_line_ready,
   output logic       rsp_return_flag,
   output logic [7:0] rsp_line_count,
   output logic [7:0] rsp_read_value
);

   localparam int TW = $clog2(TX_DEPTH);
   localparam int LW = $clog2(LINE_DEPTH);
   localparam logic [TW-1:0] TX_LAST   = TW'(TX_DEPTH - 1);
   localparam logic [LW-1:0] LINE_LAST = LW'(LINE_DEPTH - 1);

   logic          rsp_valid_ff, rsp_valid_in;
   logic          accepted_ff, accepted_in;
   logic          send_valid_ff, send_valid_in;
   logic          read_ok_ff, read_ok_in;
   logic [TW-1:0] wr_pos_ff, wr_pos_in;
   logic [TW-1:0] rd_pos_ff, rd_pos_in;
   logic          send_en_ff, send_en_in;
   logic [LW-1:0] line_len_ff, line_len_in;
   logic          line_done_ff, line_done_in;
   logic          ret_seen_ff, ret_seen_in;

   logic          take;
   logic [TW-1:0] wr_next;
   logic [TW-1:0] rd_next;
   logic          tx_we, tx_re;
   logic          line_we, line_re;
   logic [7:0]    line_wdata;
   logic [7:0]    tx_rdata, line_rdata;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   assign wr_next = (wr_pos_ff == TX_LAST) ? '0 : wr_pos_ff + 1'b1;
   assign rd_next = (rd_pos_ff == TX_LAST) ? '0 : rd_pos_ff + 1'b1;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      accepted_in   = accepted_ff;
      send_valid_in = send_valid_ff;
      read_ok_in    = read_ok_ff;
      wr_pos_in     = wr_pos_ff;
      rd_pos_in     = rd_pos_ff;
      send_en_in    = send_en_ff;
      line_len_in   = line_len_ff;
      line_done_in  = line_done_ff;
      ret_seen_in   = ret_seen_ff;
      tx_we         = 1'b0;
      tx_re         = 1'b0;
      line_we       = 1'b0;
      line_re       = 1'b0;
      line_wdata    = req_data_byte;

      if (take) begin
         rsp_valid_in  = 1'b1;
         accepted_in   = 1'b0;
         send_valid_in = 1'b0;
         read_ok_in    = 1'b0;
         case (req_command)
            utxrl_pkg::CMD_PUSH: begin
               // The enable is set even when the ring is full, so it drains.
               send_en_in = 1'b1;
               if (wr_next != rd_pos_ff) begin
                  tx_we       = 1'b1;
                  wr_pos_in   = wr_next;
                  accepted_in = 1'b1;
               end
            end
            utxrl_pkg::CMD_TX_RDY: begin
               if (send_en_ff) begin
                  if (wr_pos_ff != rd_pos_ff) begin
                     tx_re         = 1'b1;
                     send_valid_in = 1'b1;
                     rd_pos_in     = rd_next;
                  end else begin
                     send_en_in = 1'b0;
                  end
               end
            end
            utxrl_pkg::CMD_RX_BYTE: begin
               if (!line_done_ff) begin
                  if (req_data_byte == utxrl_pkg::CH_CR) begin
                     ret_seen_in = 1'b1;
                  end else if (req_data_byte == utxrl_pkg::CH_LF) begin
                     line_we      = 1'b1;
                     line_wdata   = 8'd0;
                     line_done_in = 1'b1;
                  end else if (line_len_ff != LINE_LAST) begin
                     line_we     = 1'b1;
                     line_len_in = line_len_ff + 1'b1;
                  end else begin
                     // Overflow drops the byte and starts the line over.
                     line_len_in  = '0;
                     line_done_in = 1'b0;
                     ret_seen_in  = 1'b0;
                  end
               end
            end
            utxrl_pkg::CMD_READ: begin
               if (32'(req_read_index) < LINE_DEPTH) begin
                  line_re    = 1'b1;
                  read_ok_in = 1'b1;
               end
            end
            utxrl_pkg::CMD_RELEASE: begin
               line_len_in  = '0;
               line_done_in = 1'b0;
               ret_seen_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         send_en_ff   <= 1'b0;
         line_len_ff  <= '0;
         line_done_ff <= 1'b0;
         ret_seen_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         send_en_ff   <= send_en_in;
         line_len_ff  <= line_len_in;
         line_done_ff <= line_done_in;
         ret_seen_ff  <= ret_seen_in;
      end
      accepted_ff   <= accepted_in;
      send_valid_ff <= send_valid_in;
      read_ok_ff    <= read_ok_in;
   end

   utxrl_ram #(
      .WIDTH (8),
      .DEPTH (TX_DEPTH)
   ) u_tx_ram (
      .clock (clock),
      .we    (tx_we),
      .waddr (wr_pos_ff),
      .wdata (req_data_byte),
      .re    (tx_re),
      .raddr (rd_pos_ff),
      .rdata (tx_rdata)
   );

   utxrl_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .waddr (line_len_ff),
      .wdata (line_wdata),
      .re    (line_re),
      .raddr (LW'(req_read_index)),
      .rdata (line_rdata)
   );

   // The status fields follow the state directly: it only moves when an item
   // is taken, which is also when the result register is reloaded.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_send_valid   = send_valid_ff;
   assign rsp_send_byte    = send_valid_ff ? tx_rdata : 8'd0;
   assign rsp_send_enabled = send_en_ff;
   assign rsp_line_ready   = line_done_ff;
   assign rsp_return_flag  = ret_seen_ff;
   assign rsp_line_count   = 8'(line_len_ff);
   assign rsp_read_value   = read_ok_ff ? line_rdata : 8'd0;

endmodule

// ===== hdl/utxrl_checker.sv =====
// Port checker for uart_tx_ring_and_line_receiver, attached with bind below.
// Depends on the top level's port list only.
module utxrl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_command,
   input logic [7:0] req_data_byte,
   input logic [7:0] req_read_index,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accepted,
   input logic       rsp_send_valid,
   input logic [7:0] rsp_send_byte,
   input logic       rsp_send_enabled,
   input logic       rsp_line_ready,
   input logic       rsp_return_flag,
   input logic [7:0] rsp_line_count,
   input logic [7:0] rsp_read_value
);

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_send_byte)
         && $stable(rsp_read_value) && $stable(rsp_line_count))
      else $error("result changed while stalled");

   // A stored push or a byte sent both leave the send enable on.
   a_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_accepted || rsp_send_valid) |-> rsp_send_enabled)
      else $error("send enable off after push or send");

   // One item is either a push or a send, never both.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_send_valid))
      else $error("push and send in one result");

   // A result follows every item taken while the output was free.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after an item was taken");

endmodule

bind uart_tx_ring_and_line_receiver utxrl_checker u_utxrl_checker (.*);
